@@ rtl/acdf_pkg.sv @@
// acdf_pkg: types, codes and constants shared by the ata command decode fifo
// used by acdf_queue and ata_command_decode_fifo; no dependencies
`default_nettype none

package acdf_pkg;

  localparam int QUEUE_DEPTH = 128;
  localparam int PTR_W       = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int FILL_W      = 8;
  localparam int FILL_EXT_W  = (CNT_W > FILL_W) ? CNT_W : FILL_W;
  localparam int CFG_IDX_W   = 2;

  localparam logic [4:0]  HEADS_RST   = 5'd16;
  localparam logic [7:0]  SECTORS_RST = 8'd63;
  localparam logic [31:0] MAX_LBA_RST = 32'hFFFF_FFFF;

  localparam logic [16:0] SC_DEF_NORMAL = 17'h0_0100;
  localparam logic [16:0] SC_DEF_EXT    = 17'h1_0000;

  typedef enum logic [2:0] {
    ST_PUSHED   = 3'd0,
    ST_NOT_DATA = 3'd1,
    ST_RANGE    = 3'd2,
    ST_FULL     = 3'd3,
    ST_POPPED   = 3'd4,
    ST_EMPTY    = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_MUL1,
    S_MUL2,
    S_CHECK,
    S_RESP
  } state_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHS_HEADS   = 2'd0,
    CFG_CHS_SECTORS = 2'd1,
    CFG_MAX_LBA     = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } opcode_e;

  typedef struct packed {
    logic        opcode;
    logic [31:0] fis_word1;
    logic [7:0]  fis_word2_low;
    logic [15:0] count_word;
    logic        class_write;
    logic        class_read;
    logic        addr_normal;
    logic        addr_extended;
    logic        no_sector_count;
  } cmd_t;

  typedef struct packed {
    status_e           status;
    logic [31:0]       out_lba;
    logic [16:0]       out_sectors;
    logic              out_is_write;
    logic [FILL_W-1:0] fill_level;
  } res_t;

  typedef struct packed {
    logic [31:0] lba;
    logic [16:0] sectors;
    logic        is_write;
  } entry_t;

  typedef struct packed {
    logic push;
    logic pop;
  } q_ctrl_t;

  typedef struct packed {
    logic              empty;
    logic              full;
    logic [FILL_W-1:0] fill;
  } q_stat_t;

endpackage

`default_nettype wire

@@ rtl/acdf_queue.sv @@
// acdf_queue: ring buffer of decoded requests with pointers and entry count
// depends on acdf_pkg for depth, entry and control/status structs
`default_nettype none

module acdf_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  acdf_pkg::q_ctrl_t ctrl_i,
  input  acdf_pkg::entry_t  wr_data_i,
  output acdf_pkg::entry_t  rd_data_o,
  output acdf_pkg::q_stat_t stat_o
);
  import acdf_pkg::*;

  entry_t              mem_q [QUEUE_DEPTH];
  entry_t              rd_q;
  logic [PTR_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic [PTR_W-1:0]    wr_ptr_q, wr_ptr_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [FILL_EXT_W-1:0] count_ext;

  always_comb begin
    rd_ptr_d = rd_ptr_q;
    wr_ptr_d = wr_ptr_q;
    count_d  = count_q;
    if (ctrl_i.push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      count_d  = count_q + CNT_W'(1);
    end else if (ctrl_i.pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      count_d  = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage has no reset; an entry is only read after it was written
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
    if (ctrl_i.pop) begin
      rd_q <= mem_q[rd_ptr_q];
    end
  end

  assign count_ext    = FILL_EXT_W'(count_q);
  assign rd_data_o    = rd_q;
  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign stat_o.fill  = count_ext[FILL_W-1:0];

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.push |-> !stat_o.full)
    else $error("push into full queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.pop |-> (!stat_o.empty && !ctrl_i.push))
    else $error("pop from empty queue or pop with push");

endmodule

`default_nettype wire

@@ rtl/ata_command_decode_fifo.sv @@
// ata_command_decode_fifo: top level, command sequencer and shared multiply-add unit
// depends on acdf_pkg and acdf_queue
//
// Usage: a command word is taken on cmd_i at a rising edge with start_i high and
// busy_o low. A push word decodes an ATA command into a read/write request
// (CHS, 28-bit or 48-bit lba) and queues it; a pop word removes the oldest one.
// Every command gives exactly one result word on res_o, shown for one cycle
// with res_valid_o high; the receiver cannot hold it off.
// Sequence: DECODE, then MUL1 and MUL2 for a CHS push and CHECK for any data push,
// then RESP; a pop, an empty pop or a non-data command goes from DECODE to RESP.
// The CHS path runs cylinder*heads+head and then *sectors+sector through one
// 22x8 multiply-add unit, one step per cycle; that unit sets the longest case.
// busy_o falls in the cycle that shows the result, so a new command can be
// taken while the strobe is high.
// Configuration: cfg_valid_i/cfg_ready_o with cfg_index_i selecting chs_heads,
// chs_sectors or max_lba; cfg_ready_o is always high. Write only while idle.
// Reset (rst_ni low, asynchronous) empties the queue, clears the sequencer and
// loads the geometry defaults of 16 heads, 63 sectors and max lba all ones.
`default_nettype none

module ata_command_decode_fifo (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  acdf_pkg::cmd_t                 cmd_i,
  output logic                           busy_o,
  output logic                           res_valid_o,
  output acdf_pkg::res_t                 res_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [acdf_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]                    cfg_data_i
);
  import acdf_pkg::*;

  state_e      state_q, state_d;
  cmd_t        cmd_q;
  logic [31:0] acc_q, acc_d;
  logic [16:0] sc_q, sc_d;
  status_e     st_q, st_d;
  res_t        res_q, res_d;
  logic        res_valid_q;
  logic        res_load;

  logic [4:0]  heads_q;
  logic [7:0]  sectors_q;
  logic [31:0] max_lba_q;

  logic [21:0] mac_a;
  logic [7:0]  mac_b;
  logic [7:0]  mac_c;
  logic [29:0] mac_y;

  logic [31:0] dec_lba;
  logic [16:0] dec_sc;
  logic        is_chs;
  logic [32:0] end_sum;
  logic [32:0] end_limit;
  logic        range_bad;

  q_ctrl_t     q_ctrl;
  q_stat_t     q_stat;
  entry_t      q_wr_data;
  entry_t      q_rd_data;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heads_q   <= HEADS_RST;
      sectors_q <= SECTORS_RST;
      max_lba_q <= MAX_LBA_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_CHS_HEADS:   heads_q   <= cfg_data_i[4:0];
        CFG_CHS_SECTORS: sectors_q <= cfg_data_i[7:0];
        CFG_MAX_LBA:     max_lba_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // shared multiply-add: step one cyl*heads+head, step two *sectors+sector
  always_comb begin
    if (state_q == S_MUL1) begin
      mac_a = 22'(cmd_q.fis_word1[23:8]);
      mac_b = 8'(heads_q);
      mac_c = 8'(cmd_q.fis_word1[27:24]);
    end else begin
      mac_a = acc_q[21:0];
      mac_b = sectors_q;
      mac_c = cmd_q.fis_word1[7:0];
    end
  end

  assign mac_y = 30'(mac_a) * 30'(mac_b) + 30'(mac_c);

  // address and count decode; 28-bit/CHS wins over 48-bit
  always_comb begin
    is_chs  = cmd_q.addr_normal && !cmd_q.fis_word1[30];
    dec_lba = '0;
    dec_sc  = '0;
    if (cmd_q.addr_normal) begin
      dec_lba = {4'b0, cmd_q.fis_word1[27:0]};
      dec_sc  = 17'(cmd_q.count_word[7:0]);
      if (dec_sc == '0 && !cmd_q.no_sector_count) begin
        dec_sc = SC_DEF_NORMAL;
      end
    end else if (cmd_q.addr_extended) begin
      dec_lba = {cmd_q.fis_word2_low, cmd_q.fis_word1[23:0]};
      dec_sc  = 17'(cmd_q.count_word);
      if (dec_sc == '0 && !cmd_q.no_sector_count) begin
        dec_sc = SC_DEF_EXT;
      end
    end
  end

  // range check at 33 bits, no wrap
  assign end_sum   = {1'b0, acc_q} + 33'(sc_q);
  assign end_limit = {1'b0, max_lba_q} + 33'd1;
  assign range_bad = !cmd_q.no_sector_count && (end_sum > end_limit);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) state_d = S_DECODE;
      end
      S_DECODE: begin
        if (cmd_q.opcode == OP_POP) begin
          state_d = S_RESP;
        end else if (!cmd_q.class_write && !cmd_q.class_read) begin
          state_d = S_RESP;
        end else if (is_chs) begin
          state_d = S_MUL1;
        end else begin
          state_d = S_CHECK;
        end
      end
      S_MUL1:  state_d = S_MUL2;
      S_MUL2:  state_d = S_CHECK;
      S_CHECK: state_d = S_RESP;
      S_RESP:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    acc_d    = acc_q;
    sc_d     = sc_q;
    st_d     = st_q;
    q_ctrl   = '0;
    res_load = 1'b0;
    unique case (state_q)
      S_IDLE: ;
      S_DECODE: begin
        if (cmd_q.opcode == OP_POP) begin
          if (q_stat.empty) begin
            st_d = ST_EMPTY;
          end else begin
            st_d        = ST_POPPED;
            q_ctrl.pop  = 1'b1;
          end
        end else if (!cmd_q.class_write && !cmd_q.class_read) begin
          st_d = ST_NOT_DATA;
        end else begin
          acc_d = dec_lba;
          sc_d  = dec_sc;
        end
      end
      S_MUL1: acc_d = 32'(mac_y[21:0]);
      // chs sector numbers start at one; sector zero wraps
      S_MUL2: acc_d = 32'(mac_y) - 32'd1;
      S_CHECK: begin
        if (range_bad) begin
          st_d = ST_RANGE;
        end else if (q_stat.full) begin
          st_d = ST_FULL;
        end else begin
          st_d        = ST_PUSHED;
          q_ctrl.push = 1'b1;
        end
      end
      S_RESP: res_load = 1'b1;
      default: ;
    endcase
  end

  assign q_wr_data.lba      = acc_q;
  assign q_wr_data.sectors  = sc_q;
  assign q_wr_data.is_write = cmd_q.class_write;

  acdf_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (q_ctrl),
    .wr_data_i (q_wr_data),
    .rd_data_o (q_rd_data),
    .stat_o    (q_stat)
  );

  always_comb begin
    res_d.status       = st_q;
    res_d.out_lba      = '0;
    res_d.out_sectors  = '0;
    res_d.out_is_write = 1'b0;
    res_d.fill_level   = q_stat.fill;
    if (st_q == ST_POPPED) begin
      res_d.out_lba      = q_rd_data.lba;
      res_d.out_sectors  = (q_rd_data.sectors == '0) ? SC_DEF_EXT : q_rd_data.sectors;
      res_d.out_is_write = q_rd_data.is_write;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start_i) begin
      cmd_q <= cmd_i;
    end
    acc_q <= acc_d;
    sc_q  <= sc_d;
    st_q  <= st_d;
    if (res_load) begin
      res_q <= res_d;
    end
  end

  assign busy_o      = (state_q != S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("command taken but sequencer not busy");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o)
    else $error("result strobe longer than one cycle");

  a_pop_sectors: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.status == ST_POPPED) |-> (res_o.out_sectors != '0))
    else $error("popped word with zero sector count");

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// testbench: random and directed command words for ata_command_decode_fifo, every result
// word checked against an untimed model of the decoder and request queue
// depends on acdf_pkg and the ata_command_decode_fifo rtl

module testbench;
  import acdf_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;

  logic                 clk_i     = 1'b0;
  logic                 rst_ni    = 1'b0;
  logic                 cmd_start = 1'b0;
  cmd_t                 cmd_word  = '0;
  logic                 cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data  = '0;
  logic                 dut_busy;
  logic                 res_strobe;
  logic                 cfg_ready;
  res_t                 res_word;

  // request queue as the block should hold it
  logic [31:0] slot_lba     [QUEUE_DEPTH];
  logic [16:0] slot_sectors [QUEUE_DEPTH];
  logic        slot_write   [QUEUE_DEPTH];
  int          head_ptr = 0;
  int          tail_ptr = 0;
  int          held_cnt = 0;
  logic [4:0]  geo_heads   = HEADS_RST;
  logic [7:0]  geo_sectors = SECTORS_RST;
  logic [31:0] lba_limit   = MAX_LBA_RST;

  cmd_t cmd_backlog[$];
  res_t expected_words[$];
  int   words_outstanding = 0;
  int   send_gap_pct      = 0;
  int   n_mismatch        = 0;
  int   cycle_cnt         = 0;

  ata_command_decode_fifo i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_start),
    .cmd_i       (cmd_word),
    .busy_o      (dut_busy),
    .res_valid_o (res_strobe),
    .res_o       (res_word),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic res_t decode_and_queue(input cmd_t c);
    res_t        r;
    logic [63:0] cyl, hd, sct, chs_v;
    logic [31:0] lba;
    logic [16:0] sc;
    logic        out_of_range;
    r = '0;
    if (c.opcode == OP_POP) begin
      if (held_cnt == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.status       = ST_POPPED;
        r.out_lba      = slot_lba[head_ptr];
        r.out_sectors  = (slot_sectors[head_ptr] == '0) ? SC_DEF_EXT : slot_sectors[head_ptr];
        r.out_is_write = slot_write[head_ptr];
        head_ptr       = (head_ptr + 1) % QUEUE_DEPTH;
        held_cnt--;
      end
    end else if (!c.class_write && !c.class_read) begin
      r.status = ST_NOT_DATA;
    end else begin
      if (c.addr_normal) begin
        if (!c.fis_word1[30]) begin
          cyl   = {48'd0, c.fis_word1[23:8]};
          hd    = {60'd0, c.fis_word1[27:24]};
          sct   = {56'd0, c.fis_word1[7:0]};
          chs_v = (cyl * {59'd0, geo_heads} + hd) * {56'd0, geo_sectors} + sct;
          // sector numbers start at one, so sector zero wraps
          lba   = chs_v[31:0] - 32'd1;
        end else begin
          lba = {4'd0, c.fis_word1[27:0]};
        end
        sc = {9'd0, c.count_word[7:0]};
        if (sc == '0 && !c.no_sector_count) sc = SC_DEF_NORMAL;
      end else if (c.addr_extended) begin
        lba = {c.fis_word2_low, c.fis_word1[23:0]};
        sc  = {1'b0, c.count_word};
        if (sc == '0 && !c.no_sector_count) sc = SC_DEF_EXT;
      end else begin
        lba = '0;
        sc  = '0;
      end
      out_of_range = !c.no_sector_count &&
                     ({2'b0, lba} + {17'd0, sc} > {2'b0, lba_limit} + 34'd1);
      if (out_of_range) begin
        r.status = ST_RANGE;
      end else if (held_cnt >= QUEUE_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        slot_lba[tail_ptr]     = lba;
        slot_sectors[tail_ptr] = sc;
        slot_write[tail_ptr]   = c.class_write;
        tail_ptr               = (tail_ptr + 1) % QUEUE_DEPTH;
        held_cnt++;
        r.status = ST_PUSHED;
      end
    end
    r.fill_level = held_cnt[FILL_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t %s: got %0h, want %0h", $time, what, got, want);
    n_mismatch++;
  endtask

  // command driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cmd_start && !dut_busy) expected_words.push_back(decode_and_queue(cmd_word));
      if (!cmd_start || !dut_busy) begin
        if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          cmd_word  <= cmd_backlog.pop_front();
          cmd_start <= 1'b1;
        end else begin
          cmd_start <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && res_strobe) begin
      if (words_outstanding > 0) words_outstanding--;
      if (expected_words.size() == 0) begin
        report_mismatch("result word with none outstanding", 64'(res_word), '0);
      end else begin
        want = expected_words.pop_front();
        if (res_word.status != want.status)
          report_mismatch("status", 64'(res_word.status), 64'(want.status));
        if (res_word.out_lba != want.out_lba)
          report_mismatch("out_lba", 64'(res_word.out_lba), 64'(want.out_lba));
        if (res_word.out_sectors != want.out_sectors)
          report_mismatch("out_sectors", 64'(res_word.out_sectors),
                          64'(want.out_sectors));
        if (res_word.out_is_write != want.out_is_write)
          report_mismatch("out_is_write", 64'(res_word.out_is_write),
                          64'(want.out_is_write));
        if (res_word.fill_level != want.fill_level)
          report_mismatch("fill_level", 64'(res_word.fill_level), 64'(want.fill_level));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("ata_command_decode_fifo: mismatch");
      $finish;
    end
  end

  task automatic send(input cmd_t c);
    cmd_backlog.push_back(c);
    words_outstanding++;
  endtask

  task automatic wait_drained();
    do @(posedge clk_i);
    while (words_outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [31:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk_i);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_CHS_HEADS:   geo_heads   = data[4:0];
      CFG_CHS_SECTORS: geo_sectors = data[7:0];
      CFG_MAX_LBA:     lba_limit   = data;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_geometry(input logic [31:0] heads, input logic [31:0] sectors,
                              input logic [31:0] limit);
    write_reg(CFG_CHS_HEADS, heads);
    write_reg(CFG_CHS_SECTORS, sectors);
    write_reg(CFG_MAX_LBA, limit);
  endtask

  function automatic cmd_t mk(input opcode_e op, input logic [31:0] w1, input logic [7:0] w2,
                              input logic [15:0] cnt, input logic cw, input logic cr,
                              input logic an, input logic ae, input logic nsc);
    cmd_t c;
    c.opcode          = op;
    c.fis_word1       = w1;
    c.fis_word2_low   = w2;
    c.count_word      = cnt;
    c.class_write     = cw;
    c.class_read      = cr;
    c.addr_normal     = an;
    c.addr_extended   = ae;
    c.no_sector_count = nsc;
    return c;
  endfunction

  function automatic cmd_t rand_word();
    return mk(opcode_e'($urandom_range(1)), $urandom, 8'($urandom_range(255)),
              16'($urandom_range(65535)), 1'($urandom_range(1)), 1'($urandom_range(1)),
              1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)));
  endfunction

  function automatic cmd_t make_pop();
    cmd_t c;
    c        = rand_word();
    c.opcode = OP_POP;
    return c;
  endfunction

  // mostly data-class commands with a usable addressing mode
  function automatic cmd_t make_push(input bit small_addr);
    cmd_t c;
    int   cls, am;
    c        = rand_word();
    c.opcode = OP_PUSH;
    if ($urandom_range(9) == 0) c.count_word = '0;
    else if ($urandom_range(3) == 0) c.count_word = 16'($urandom_range(1, 8));
    cls = $urandom_range(19);
    c.class_write = (cls < 8) || (cls >= 16 && cls < 19);
    c.class_read  = (cls >= 8 && cls < 19);
    am = $urandom_range(19);
    c.addr_normal     = (am < 9) || (am == 18);
    c.addr_extended   = (am >= 9 && am < 19);
    c.no_sector_count = ($urandom_range(9) == 0);
    if (small_addr) begin
      c.fis_word1     = c.fis_word1 & 32'h4000_0FFF;
      c.fis_word2_low = '0;
    end
    return c;
  endfunction

  task automatic queue_random(input int n);
    int push_pct, r;
    push_pct = 55;
    for (int i = 0; i < n; i++) begin
      // bursts that lean toward filling or draining the queue
      if (i % 40 == 0) begin
        case ($urandom_range(2))
          0:       push_pct = 85;
          1:       push_pct = 20;
          default: push_pct = 55;
        endcase
      end
      r = $urandom_range(99);
      if (r < 5) send(rand_word());
      else if (r < push_pct) send(make_push(1'($urandom_range(1))));
      else send(make_pop());
    end
  endtask

  initial begin
    cmd_t c;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: corner cases at reset geometry
    send(mk(OP_POP,  32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 1, 1, 1, 1, 1));
    send(mk(OP_PUSH, 32'h0000_0001, 8'h00, 16'h0000, 1, 0, 1, 0, 0));
    send(mk(OP_PUSH, 32'h0000_0000, 8'h00, 16'h0000, 0, 1, 1, 0, 1));
    send(mk(OP_PUSH, 32'h0000_0000, 8'h00, 16'h0001, 1, 0, 1, 0, 0));
    send(mk(OP_PUSH, 32'h0FFF_FFFF, 8'h00, 16'hFF00, 0, 1, 1, 0, 0));
    send(mk(OP_PUSH, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 1, 1, 1, 0, 0));
    send(mk(OP_PUSH, 32'hFFFF_FFFF, 8'hFF, 16'h0001, 0, 1, 0, 1, 0));
    send(mk(OP_PUSH, 32'hFFFF_FFFF, 8'hFF, 16'h0002, 0, 1, 0, 1, 0));
    send(mk(OP_PUSH, 32'h0000_0000, 8'h00, 16'h0000, 1, 0, 0, 1, 0));
    send(mk(OP_PUSH, 32'h4000_1234, 8'h77, 16'h0305, 1, 0, 1, 1, 0));
    send(mk(OP_PUSH, 32'h1234_5678, 8'h9A, 16'hBCDE, 1, 0, 0, 0, 0));
    send(mk(OP_PUSH, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 0, 0, 0, 1, 0));
    send(mk(OP_PUSH, 32'h00FF_FFFF, 8'h12, 16'h0000, 0, 1, 0, 1, 1));
    for (int i = 0; i < 10; i++) send(mk(OP_POP, '0, '0, '0, 0, 0, 0, 0, 0));
    wait_drained();

    // zero geometry multiplies through as is
    write_reg(CFG_CHS_HEADS, 32'd0);
    write_reg(CFG_CHS_SECTORS, 32'd0);
    send(mk(OP_PUSH, 32'h0012_3405, 8'h00, 16'h0001, 1, 0, 1, 0, 0));
    send(mk(OP_POP,  32'h0000_0000, 8'h00, 16'h0000, 0, 0, 0, 0, 0));
    wait_drained();

    // phase one: fill past full, drain past empty, then random
    send_gap_pct = 9;
    set_geometry(32'd16, 32'd63, 32'hFFFF_FFFF);
    for (int i = 0; i < 135; i++) begin
      c = make_push(1'b0);
      c.addr_normal   = 1'b0;
      c.addr_extended = 1'b1;
      c.fis_word2_low = 8'($urandom_range(254));
      if (!c.class_write && !c.class_read) c.class_read = 1'b1;
      send(c);
    end
    // range check and class check still come ahead of the full check
    send(mk(OP_PUSH, 32'hFFFF_FFFF, 8'hFF, 16'h0005, 1, 0, 0, 1, 0));
    send(mk(OP_PUSH, 32'h0000_0010, 8'h00, 16'h0001, 0, 0, 1, 0, 0));
    for (int i = 0; i < 131; i++) send(make_pop());
    queue_random(200);
    wait_drained();

    send_gap_pct = 68;
    set_geometry(32'd1, 32'd255, 32'h00FF_FFFF);
    queue_random(450);
    wait_drained();

    send_gap_pct = 0;
    set_geometry(32'd1, 32'd1, 32'd0);
    queue_random(30);
    wait_drained();

    set_geometry(32'd31, 32'd255, 32'h7FFF_FFFF);
    queue_random(400);
    wait_drained();

    if (n_mismatch == 0) begin
      $display("ata_command_decode_fifo: match");
    end else begin
      $display("ata_command_decode_fifo: mismatch");
    end
    $finish;
  end

endmodule
